>>> hdl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the elliptic-curve scalar multiply core.
// ----------------------------------------------------------------------------
package ecc_pkg;

    // Field and scalar sizes
    localparam int FIELD_BITS  = 63;
    localparam int SCALAR_BITS = 64;
    localparam int IDX_W       = $clog2(SCALAR_BITS);

    // Working word of the arithmetic unit and its step counter
    localparam int WORD_W = 64;
    localparam int CNT_W  = $clog2(WORD_W);

    // Register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic REG_FIELD_PRIME = 1'b0;
    localparam logic REG_CURVE_A     = 1'b1;

    localparam logic [FIELD_BITS-1:0] FIELD_PRIME_RST = FIELD_BITS'(257);
    localparam logic [FIELD_BITS-1:0] CURVE_A_RST     = FIELD_BITS'(2);

    typedef logic [WORD_W-1:0] word_t;

    // Operations of the shared modular unit
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

    // Input item
    typedef struct packed {
        logic [SCALAR_BITS-1:0] scalar;
        logic [FIELD_BITS-1:0]  base_x;
        logic [FIELD_BITS-1:0]  base_y;
        logic                   base_at_infinity;
    } item_t;

    // Result item
    typedef struct packed {
        logic [FIELD_BITS-1:0] result_x;
        logic [FIELD_BITS-1:0] result_y;
        logic                  result_at_infinity;
    } result_t;

endpackage

>>> hdl/ecc_mod_unit.sv
// ----------------------------------------------------------------------------
// ecc_mod_unit
// Shared modular arithmetic unit: add and subtract, bit-serial modular
// multiply and restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module ecc_mod_unit
    import ecc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    input  word_t    opa,
    input  word_t    opb,
    input  word_t    modulus,
    output logic     done,
    output word_t    res,
    output word_t    rem
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    alu_op_t             op_reg, op_next;
    word_t               a_reg, a_next;
    word_t               b_reg, b_next;
    word_t               acc_reg, acc_next;
    logic [WORD_W:0]     rm_reg, rm_next;
    logic [WORD_W:0]     rm_shift;
    word_t               dbl;

    // Sum with a single conditional subtraction of the modulus.
    function automatic word_t fadd(input word_t x, input word_t y, input word_t m);
        word_t s;
        s = x + y;
        return (s >= m) ? s - m : s;
    endfunction

    // Difference that wraps through the modulus when it would go negative.
    function automatic word_t fsub(input word_t x, input word_t y, input word_t m);
        return (x >= y) ? x - y : x + (m - y);
    endfunction

    // Next state of the unit
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rm_next   = rm_reg;
        rm_shift  = {rm_reg[WORD_W-1:0], a_reg[WORD_W-1]};
        dbl       = fadd(acc_reg, acc_reg, modulus);
        if (req.start)
        begin
            op_next  = req.op;
            a_next   = opa;
            b_next   = opb;
            acc_next = '0;
            rm_next  = '0;
            cnt_next = '0;
            unique case (req.op)
                OP_ADD:
                begin
                    acc_next  = fadd(opa, opb, modulus);
                    done_next = 1'b1;
                end
                OP_SUB:
                begin
                    acc_next  = fsub(opa, opb, modulus);
                    done_next = 1'b1;
                end
                OP_MUL, OP_DIV:
                begin
                    busy_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    // Double, then add the multiplicand where the bit is set.
                    acc_next = b_reg[WORD_W-1] ? fadd(dbl, a_reg, modulus) : dbl;
                    b_next   = {b_reg[WORD_W-2:0], 1'b0};
                end
                OP_DIV:
                begin
                    // Restoring division: quotient bits shift into a_reg.
                    if (rm_shift >= {1'b0, b_reg})
                    begin
                        rm_next = rm_shift - {1'b0, b_reg};
                        a_next  = {a_reg[WORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rm_next = rm_shift;
                        a_next  = {a_reg[WORD_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_ADD;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rm_reg  <= rm_next;
    end

    assign done = done_reg;
    assign res  = (op_reg == OP_DIV) ? a_reg : acc_reg;
    assign rem  = rm_reg[WORD_W-1:0];

endmodule

>>> hdl/ecc_seq.sv
// ----------------------------------------------------------------------------
// ecc_seq
// Sequencer for left-to-right double-and-add with affine point formulas and
// extended-Euclid inversion, all driven through the shared modular unit.
// ----------------------------------------------------------------------------
module ecc_seq
    import ecc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  item_t                 item_in,
    input  logic [FIELD_BITS-1:0] field_prime,
    input  logic [FIELD_BITS-1:0] curve_a,
    input  logic                  out_free,
    output seq_status_t           status,
    output result_t               result_out
);

    typedef enum logic [5:0] {
        S_IDLE, S_START, S_RA, S_RX, S_RY, S_WAIT,
        S_BIT, S_DBL, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9,
        S_D10, S_D11, S_D12,
        S_I_INIT, S_I_LOOP, S_I_Q, S_I_T, S_I_N,
        S_AFTER, S_NEXT,
        S_ADD, S_A_EQ, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6
    } state_t;

    state_t                 state_reg, state_next;
    state_t                 ret_reg, ret_next;
    state_t                 iret_reg, iret_next;
    logic                   ph_add_reg, ph_add_next;
    logic                   ainf_reg, ainf_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SCALAR_BITS-1:0] k_reg, k_next;
    word_t bx_reg, bx_next, by_reg, by_next, ar_reg, ar_next;
    word_t ax_reg, ax_next, ay_reg, ay_next, ta_reg, ta_next, lam_reg, lam_next;
    word_t r0_reg, r0_next, r1_reg, r1_next, e0_reg, e0_next, e1_reg, e1_next;

    alu_req_t alu_req;
    word_t    alu_a, alu_b, alu_res, alu_rem, m;
    logic     alu_done;

    assign m = {{(WORD_W-FIELD_BITS){1'b0}}, field_prime};

    ecc_mod_unit u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .modulus (m),
        .done    (alu_done),
        .res     (alu_res),
        .rem     (alu_rem)
    );

    // Step sequencing; every arithmetic step goes through S_WAIT.
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        iret_next   = iret_reg;
        ph_add_next = ph_add_reg;
        ainf_next   = ainf_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        ar_next     = ar_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        ta_next     = ta_reg;
        lam_next    = lam_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        e0_next     = e0_reg;
        e1_next     = e1_reg;
        alu_req     = '{start: 1'b0, op: OP_ADD};
        alu_a       = '0;
        alu_b       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    k_next    = item_in.scalar;
                    bx_next   = {{(WORD_W-FIELD_BITS){1'b0}}, item_in.base_x};
                    by_next   = {{(WORD_W-FIELD_BITS){1'b0}}, item_in.base_y};
                    ainf_next = 1'b1;
                    if (field_prime < FIELD_BITS'(2) || item_in.scalar == '0 ||
                        item_in.base_at_infinity)
                        state_next = S_D12;
                    else
                        state_next = S_START;
                end
            end
            // Reduce a and the base coordinates modulo p.
            S_START:
            begin
                alu_req    = '{start: 1'b1, op: OP_DIV};
                alu_a      = {{(WORD_W-FIELD_BITS){1'b0}}, curve_a};
                alu_b      = m;
                ret_next   = S_RA;
                state_next = S_WAIT;
            end
            S_RA:
            begin
                ar_next    = alu_rem;
                alu_req    = '{start: 1'b1, op: OP_DIV};
                alu_a      = bx_reg;
                alu_b      = m;
                ret_next   = S_RX;
                state_next = S_WAIT;
            end
            S_RX:
            begin
                bx_next    = alu_rem;
                alu_req    = '{start: 1'b1, op: OP_DIV};
                alu_a      = by_reg;
                alu_b      = m;
                ret_next   = S_RY;
                state_next = S_WAIT;
            end
            S_RY:
            begin
                by_next    = alu_rem;
                idx_next   = IDX_W'(SCALAR_BITS - 1);
                state_next = S_BIT;
            end
            S_WAIT:
            begin
                if (alu_done)
                    state_next = ret_reg;
            end
            S_BIT:
            begin
                ph_add_next = 1'b0;
                state_next  = S_DBL;
            end
            // Point doubling
            S_DBL:
            begin
                if (ainf_reg || ay_reg == '0)
                begin
                    ainf_next  = 1'b1;
                    state_next = S_AFTER;
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: OP_MUL};
                    alu_a      = ax_reg;
                    alu_b      = ax_reg;
                    ret_next   = S_D1;
                    state_next = S_WAIT;
                end
            end
            S_D1:
            begin
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = WORD_W'(3);
                alu_b      = alu_res;
                ret_next   = S_D2;
                state_next = S_WAIT;
            end
            S_D2:
            begin
                alu_req    = '{start: 1'b1, op: OP_ADD};
                alu_a      = alu_res;
                alu_b      = ar_reg;
                ret_next   = S_D3;
                state_next = S_WAIT;
            end
            S_D3:
            begin
                ta_next    = alu_res;
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = WORD_W'(2);
                alu_b      = ay_reg;
                ret_next   = S_D4;
                state_next = S_WAIT;
            end
            S_D4:
            begin
                alu_req    = '{start: 1'b1, op: OP_DIV};
                alu_a      = alu_res;
                alu_b      = m;
                iret_next  = S_D5;
                ret_next   = S_I_INIT;
                state_next = S_WAIT;
            end
            S_D5:
            begin
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = ta_reg;
                alu_b      = e0_reg;
                ret_next   = S_D6;
                state_next = S_WAIT;
            end
            S_D6:
            begin
                lam_next   = alu_res;
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = alu_res;
                alu_b      = alu_res;
                ret_next   = S_D7;
                state_next = S_WAIT;
            end
            S_D7:
            begin
                ta_next    = alu_res;
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = WORD_W'(2);
                alu_b      = ax_reg;
                ret_next   = S_D8;
                state_next = S_WAIT;
            end
            S_D8:
            begin
                alu_req    = '{start: 1'b1, op: OP_SUB};
                alu_a      = ta_reg;
                alu_b      = alu_res;
                ret_next   = S_D9;
                state_next = S_WAIT;
            end
            // New x is in hand; shared tail of doubling and addition.
            S_D9:
            begin
                ta_next    = alu_res;
                alu_req    = '{start: 1'b1, op: OP_SUB};
                alu_a      = ax_reg;
                alu_b      = alu_res;
                ret_next   = S_D10;
                state_next = S_WAIT;
            end
            S_D10:
            begin
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = lam_reg;
                alu_b      = alu_res;
                ret_next   = S_D11;
                state_next = S_WAIT;
            end
            S_D11:
            begin
                alu_req    = '{start: 1'b1, op: OP_SUB};
                alu_a      = alu_res;
                alu_b      = ay_reg;
                ret_next   = S_D12;
                state_next = S_WAIT;
            end
            // Also serves as the final state holding the result.
            S_D12:
            begin
                if (ainf_reg && ret_reg != S_D12)
                begin
                    state_next = out_free ? S_IDLE : S_D12;
                end
                else if (ret_reg == S_D12 && !ainf_reg)
                begin
                    ax_next    = ta_reg;
                    ay_next    = alu_res;
                    ainf_next  = 1'b0;
                    ret_next   = S_AFTER;
                    state_next = S_AFTER;
                end
                else
                begin
                    state_next = out_free ? S_IDLE : S_D12;
                end
            end
            // Extended Euclid: r1 arrives as the remainder of the argument.
            S_I_INIT:
            begin
                r0_next    = m;
                r1_next    = alu_rem;
                e0_next    = '0;
                e1_next    = WORD_W'(1);
                state_next = S_I_LOOP;
            end
            S_I_LOOP:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg == WORD_W'(1))
                        state_next = iret_reg;
                    else
                    begin
                        ainf_next  = 1'b1;
                        state_next = S_AFTER;
                    end
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: OP_DIV};
                    alu_a      = r0_reg;
                    alu_b      = r1_reg;
                    ret_next   = S_I_Q;
                    state_next = S_WAIT;
                end
            end
            S_I_Q:
            begin
                r0_next    = r1_reg;
                r1_next    = alu_rem;
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = (alu_res == m) ? '0 : alu_res;
                alu_b      = e1_reg;
                ret_next   = S_I_T;
                state_next = S_WAIT;
            end
            S_I_T:
            begin
                alu_req    = '{start: 1'b1, op: OP_SUB};
                alu_a      = e0_reg;
                alu_b      = alu_res;
                ret_next   = S_I_N;
                state_next = S_WAIT;
            end
            S_I_N:
            begin
                e0_next    = e1_reg;
                e1_next    = alu_res;
                state_next = S_I_LOOP;
            end
            S_AFTER:
            begin
                ret_next = S_AFTER;
                if (!ph_add_reg && k_reg[idx_reg])
                    state_next = S_ADD;
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (idx_reg == '0)
                begin
                    ret_next   = S_NEXT;
                    state_next = S_D12;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_BIT;
                end
            end
            // Point addition of the base
            S_ADD:
            begin
                ph_add_next = 1'b1;
                if (ainf_reg)
                begin
                    ax_next    = bx_reg;
                    ay_next    = by_reg;
                    ainf_next  = 1'b0;
                    state_next = S_NEXT;
                end
                else if (ax_reg == bx_reg)
                begin
                    alu_req    = '{start: 1'b1, op: OP_ADD};
                    alu_a      = ay_reg;
                    alu_b      = by_reg;
                    ret_next   = S_A_EQ;
                    state_next = S_WAIT;
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: OP_SUB};
                    alu_a      = bx_reg;
                    alu_b      = ax_reg;
                    ret_next   = S_A1;
                    state_next = S_WAIT;
                end
            end
            S_A_EQ:
            begin
                if (alu_res == '0)
                begin
                    ainf_next  = 1'b1;
                    state_next = S_NEXT;
                end
                else
                    state_next = S_DBL;
            end
            S_A1:
            begin
                alu_req    = '{start: 1'b1, op: OP_DIV};
                alu_a      = alu_res;
                alu_b      = m;
                iret_next  = S_A2;
                ret_next   = S_I_INIT;
                state_next = S_WAIT;
            end
            S_A2:
            begin
                alu_req    = '{start: 1'b1, op: OP_SUB};
                alu_a      = by_reg;
                alu_b      = ay_reg;
                ret_next   = S_A3;
                state_next = S_WAIT;
            end
            S_A3:
            begin
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = alu_res;
                alu_b      = e0_reg;
                ret_next   = S_A4;
                state_next = S_WAIT;
            end
            // The slope squared, less both x coordinates, gives the new x.
            S_A4:
            begin
                lam_next   = alu_res;
                alu_req    = '{start: 1'b1, op: OP_MUL};
                alu_a      = alu_res;
                alu_b      = alu_res;
                ret_next   = S_A5;
                state_next = S_WAIT;
            end
            S_A5:
            begin
                alu_req    = '{start: 1'b1, op: OP_SUB};
                alu_a      = alu_res;
                alu_b      = ax_reg;
                ret_next   = S_A6;
                state_next = S_WAIT;
            end
            S_A6:
            begin
                alu_req    = '{start: 1'b1, op: OP_SUB};
                alu_a      = alu_res;
                alu_b      = bx_reg;
                ret_next   = S_D9;
                state_next = S_WAIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            iret_reg   <= S_IDLE;
            ph_add_reg <= 1'b0;
            ainf_reg   <= 1'b1;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            iret_reg   <= iret_next;
            ph_add_reg <= ph_add_next;
            ainf_reg   <= ainf_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        bx_reg  <= bx_next;
        by_reg  <= by_next;
        ar_reg  <= ar_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        ta_reg  <= ta_next;
        lam_reg <= lam_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        e0_reg  <= e0_next;
        e1_reg  <= e1_next;
    end

    // The result is final in S_D12 once no point update is pending there.
    assign status.idle = (state_reg == S_IDLE);
    assign status.done = (state_reg == S_D12) && (ainf_reg || ret_reg != S_D12);

    assign result_out.result_x           = ainf_reg ? '0 : ax_reg[FIELD_BITS-1:0];
    assign result_out.result_y           = ainf_reg ? '0 : ay_reg[FIELD_BITS-1:0];
    assign result_out.result_at_infinity = ainf_reg;

endmodule

>>> hdl/ecc_point_scalar_multiply_core.sv
// ----------------------------------------------------------------------------
// ecc_point_scalar_multiply_core
// Affine elliptic-curve scalar multiplication k*P over a prime field.
// ----------------------------------------------------------------------------
// One item is processed at a time. The scalar is scanned from bit 63 down;
// each point doubling or addition takes one field inversion by extended
// Euclid plus up to seven modular products, all on one shared unit whose
// multiply and division work one bit per cycle. Each Euclid step of the
// inversion is a division, a product and a subtraction on that unit. The
// field prime is 63 bits wide and the scalar 64 bits; a scalar bit that
// leaves the accumulator at infinity needs no arithmetic, and a zero
// scalar, a point at infinity or a modulus below two skips the scan and
// goes straight to the result. The next item is taken once the sequencer
// is back in idle; a finished result waits in the output register. The
// field prime (address 0x0) and curve coefficient a (address 0x8) may only
// be written while idle.
module ecc_point_scalar_multiply_core
    import ecc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Input items
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    // Result items
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [FIELD_BITS-1:0] prime_reg;
    logic [FIELD_BITS-1:0] curve_a_reg;
    logic                  result_valid_reg;
    result_t               result_reg;
    seq_status_t           seq_status;
    result_t               seq_result;
    logic                  out_free;
    logic                  start;
    logic                  reg_sel;

    assign reg_sel = paddr[3];
    assign pready  = 1'b1;

    // Register writes at the access phase of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg   <= FIELD_PRIME_RST;
            curve_a_reg <= CURVE_A_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_FIELD_PRIME: prime_reg   <= pwdata[FIELD_BITS-1:0];
                REG_CURVE_A:     curve_a_reg <= pwdata[FIELD_BITS-1:0];
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_sel)
            REG_FIELD_PRIME: prdata = {{(PDATA_W-FIELD_BITS){1'b0}}, prime_reg};
            REG_CURVE_A:     prdata = {{(PDATA_W-FIELD_BITS){1'b0}}, curve_a_reg};
        endcase
    end

    assign item_ready = seq_status.idle;
    assign start      = item_valid && seq_status.idle;
    assign out_free   = !result_valid_reg || result_ready;

    ecc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item_in     (item),
        .field_prime (prime_reg),
        .curve_a     (curve_a_reg),
        .out_free    (out_free),
        .status      (seq_status),
        .result_out  (seq_result)
    );

    // Output register: loaded when the sequencer finishes and the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (seq_status.done && out_free)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (seq_status.done && out_free)
            result_reg <= seq_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
